/* rtl/sldr_pkg.sv */
// Shared types and constants for the sync word length deframer router.
`default_nettype none
package sldr_pkg;

  localparam int unsigned LenW     = 21;
  localparam int unsigned WordW    = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned HdrBytes = 8;
  localparam int unsigned BeatW    = 3;

  localparam logic [CfgIdxW-1:0] RegSyncWord = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinLen   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxLen   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpecLen  = 2'd3;

  localparam logic [WordW-1:0] SyncWordRst = 32'hFDB1_8540;
  localparam logic [LenW-1:0]  MinLenRst   = 21'd85;
  localparam logic [LenW-1:0]  MaxLenRst   = 21'd1048576;
  localparam logic [LenW-1:0]  SpecLenRst  = 21'd428;

  localparam logic [LenW-1:0]  HdrLen      = 21'd8;
  localparam logic [BeatW-1:0] LastBeat    = 3'd7;

  // One queued unit of work: a whole header (eight bytes) or one body byte.
  typedef struct packed {
    logic                is_hdr;
    logic                last;
    logic                route;
    logic [LenW-1:0]     length;
    logic [8*HdrBytes-1:0] data;  // first byte in the top bits
  } entry_t;

endpackage
`default_nettype wire

/* rtl/sldr_front.sv */
// Front end: hunting window, header check and frame tracking.
`default_nettype none
module sldr_front import sldr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [WordW-1:0]   cfg_data_i,
  input  wire logic               acc_i,
  input  wire logic [7:0]         data_byte_i,
  output      logic               push_o,
  output      entry_t             entry_o
);

  logic [WordW-1:0] sync_q;
  logic [LenW-1:0]  min_q, max_q, spec_q;
  logic [7:0]       win_q [HdrBytes-1];
  logic [7:0]       win_d [HdrBytes-1];
  logic [BeatW-1:0] fill_q, fill_d;
  logic             in_frame_q, in_frame_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic             route_q, route_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [WordW-1:0] sync_cand, len_cand;
  logic             bad_len, body_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SyncWordRst;
      min_q  <= MinLenRst;
      max_q  <= MaxLenRst;
      spec_q <= SpecLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSyncWord: sync_q <= cfg_data_i;
        RegMinLen:   min_q  <= cfg_data_i[LenW-1:0];
        RegMaxLen:   max_q  <= cfg_data_i[LenW-1:0];
        RegSpecLen:  spec_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign sync_cand = {win_q[0], win_q[1], win_q[2], win_q[3]};
  assign len_cand  = {win_q[4], win_q[5], win_q[6], data_byte_i};
  assign bad_len   = len_cand[WordW-1]
                   || (len_cand <= {{(WordW-LenW){1'b0}}, min_q})
                   || (len_cand >  {{(WordW-LenW){1'b0}}, max_q})
                   || (len_cand <  {{(WordW-LenW){1'b0}}, HdrLen});
  assign body_last = (rem_q == {{(LenW-1){1'b0}}, 1'b1});

  always_comb begin
    win_d      = win_q;
    fill_d     = fill_q;
    in_frame_d = in_frame_q;
    rem_d      = rem_q;
    route_d    = route_q;
    len_d      = len_q;
    push_o     = 1'b0;
    entry_o    = '0;
    if (acc_i) begin
      if (in_frame_q) begin
        push_o         = 1'b1;
        entry_o.last   = body_last;
        entry_o.route  = route_q;
        entry_o.length = len_q;
        entry_o.data   = {data_byte_i, {(8*(HdrBytes-1)){1'b0}}};
        rem_d          = rem_q - 1'b1;
        if (body_last) in_frame_d = 1'b0;
      end else if (fill_q != LastBeat) begin
        win_d[fill_q] = data_byte_i;
        fill_d        = fill_q + 1'b1;
      end else if (sync_cand != sync_q) begin
        // slide by one byte
        for (int i = 0; i < HdrBytes-2; i++) win_d[i] = win_q[i+1];
        win_d[HdrBytes-2] = data_byte_i;
        fill_d = LastBeat;
      end else if (bad_len) begin
        // drop the sync bytes, keep hunting on the length bytes
        for (int i = 0; i < 3; i++) win_d[i] = win_q[i+4];
        win_d[3] = data_byte_i;
        fill_d   = 3'd4;
      end else begin
        push_o         = 1'b1;
        len_d          = len_cand[LenW-1:0];
        route_d        = (len_cand[LenW-1:0] != spec_q);
        rem_d          = len_cand[LenW-1:0] - HdrLen;
        in_frame_d     = (len_cand[LenW-1:0] != HdrLen);
        fill_d         = '0;
        entry_o.is_hdr = 1'b1;
        entry_o.last   = (len_cand[LenW-1:0] == HdrLen);
        entry_o.route  = route_d;
        entry_o.length = len_d;
        entry_o.data   = {sync_cand, len_cand};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      in_frame_q <= 1'b0;
      rem_q      <= '0;
      route_q    <= 1'b0;
      len_q      <= '0;
    end else begin
      fill_q     <= fill_d;
      in_frame_q <= in_frame_d;
      rem_q      <= rem_d;
      route_q    <= route_d;
      len_q      <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule
`default_nettype wire

/* rtl/sldr_queue.sv */
// Small FIFO of work entries between the front and back ends.
`default_nettype none
module sldr_queue import sldr_pkg::*; #(
  parameter int unsigned Depth = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t push_data_i,
  input  wire logic   pop_i,
  output      logic   full_o,
  output      logic   empty_o,
  output      entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

/* rtl/sldr_back.sv */
// Back end: expands queued entries into output bytes behind an output register.
`default_nettype none
module sldr_back import sldr_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire entry_t          head_i,
  output      logic            pop_o,
  output      logic            out_valid_o,
  input  wire logic            out_ready_i,
  output      logic [7:0]      out_byte_o,
  output      logic            route_group_o,
  output      logic            frame_start_o,
  output      logic            frame_end_o,
  output      logic [LenW-1:0] frame_length_o
);

  logic [BeatW-1:0] beat_q;
  logic             valid_q;
  logic             load, last_beat;
  logic [7:0]       byte_q;
  logic             route_q, start_q, end_q;
  logic [LenW-1:0]  len_q;

  assign load      = !empty_i && (!valid_q || out_ready_i);
  assign last_beat = !head_i.is_hdr || (beat_q == LastBeat);
  assign pop_o     = load && last_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= '0;
    end else begin
      if (load)             valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
      // advance through the header beats, restart on pop
      if (pop_o)     beat_q <= '0;
      else if (load) beat_q <= beat_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= head_i.data[8*(LastBeat - beat_q) +: 8];
      route_q <= head_i.route;
      start_q <= head_i.is_hdr && (beat_q == '0);
      end_q   <= head_i.last && last_beat;
      len_q   <= head_i.length;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign route_group_o  = route_q;
  assign frame_start_o  = start_q;
  assign frame_end_o    = end_q;
  assign frame_length_o = len_q;

endmodule
`default_nettype wire

/* rtl/sync_length_deframer_router_unit.sv */
// Top level of the sync word length-prefixed deframer and router.
// Bytes are taken one per cycle. The front end hunts for the sync word in an
// eight-byte window, checks the big-endian length that follows, and queues
// either a whole header or a single body byte; the back end drains the queue
// into a registered output, one byte per cycle while the sink is ready, so a
// header fans out into eight transfers while body bytes keep streaming into the
// queue. Input is stalled only when the queue (Depth entries) is full; with a
// continuously ready sink and Depth of at least 9, one byte per cycle is
// sustained. Each output byte is registered from the entry at the queue head.
// Configuration registers are written by index and take effect at the next
// header.
`default_nettype none
module sync_length_deframer_router_unit import sldr_pkg::*; #(
  parameter int unsigned Depth = 9
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [WordW-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [7:0]         data_byte_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [7:0]         out_byte_o,
  output      logic               route_group_o,
  output      logic               frame_start_o,
  output      logic               frame_end_o,
  output      logic [LenW-1:0]    frame_length_o
);

  logic   acc, push, pop, full, empty;
  entry_t push_entry, head;

  assign in_ready_o = !full;
  assign acc        = in_valid_i && !full;

  sldr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  sldr_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head)
  );

  sldr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .route_group_o  (route_group_o),
    .frame_start_o  (frame_start_o),
    .frame_end_o    (frame_end_o),
    .frame_length_o (frame_length_o)
  );

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Testbench for the sync word deframer and router: random and directed byte streams, scoreboard.
`timescale 1ns / 1ps
module testbench;
  import sldr_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned PhaseBytes = 32;

  typedef struct packed {
    logic [7:0]      data;
    logic            route;
    logic            start;
    logic            last;
    logic [LenW-1:0] length;
  } frame_beat_t;

  // Tracks the deframer's hunting window and open frame, and holds the beats still owed.
  class frame_scoreboard;
    logic [WordW-1:0] sync_word;
    logic [LenW-1:0]  min_len;
    logic [LenW-1:0]  max_len;
    logic [LenW-1:0]  spec_len;
    logic [7:0]       win [8];
    int unsigned      fill;
    bit               framing;
    int unsigned      body_left;
    logic             route;
    logic [LenW-1:0]  cur_len;
    frame_beat_t      owed [$];
    int unsigned      errors;

    function new();
      sync_word = SyncWordRst;
      min_len   = MinLenRst;
      max_len   = MaxLenRst;
      spec_len  = SpecLenRst;
      fill      = 0;
      framing   = 1'b0;
      body_left = 0;
      route     = 1'b0;
      cur_len   = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] value);
      case (idx)
        RegSyncWord: sync_word = value;
        RegMinLen:   min_len   = value[LenW-1:0];
        RegMaxLen:   max_len   = value[LenW-1:0];
        RegSpecLen:  spec_len  = value[LenW-1:0];
        default: ;
      endcase
    endfunction

    function void shift_window(int unsigned n);
      if (n > fill) n = fill;
      for (int unsigned i = 0; i + n < fill; i++) win[i] = win[i + n];
      fill -= n;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [31:0] len;
      frame_beat_t beat;
      if (framing) begin
        if (body_left > 0) body_left--;
        beat = '{data: b, route: route, start: 1'b0, last: (body_left == 0),
                 length: cur_len};
        owed.push_back(beat);
        if (body_left == 0) framing = 1'b0;
        return;
      end
      if (fill >= HdrBytes) fill = 0;
      win[fill[2:0]] = b;
      fill++;
      if (fill < HdrBytes) return;
      if ({win[0], win[1], win[2], win[3]} != sync_word) begin
        shift_window(1);
        return;
      end
      len = {win[4], win[5], win[6], win[7]};
      // negative, too short, or outside the configured bounds: drop the sync bytes
      if (len[31] || len <= 32'(min_len) || len > 32'(max_len) || len < HdrBytes) begin
        shift_window(4);
        return;
      end
      cur_len   = len[LenW-1:0];
      route     = (cur_len != spec_len);
      body_left = cur_len - HdrBytes;
      for (int unsigned i = 0; i < HdrBytes; i++) begin
        beat = '{data: win[i], route: route, start: (i == 0),
                 last: (i == HdrBytes - 1 && body_left == 0), length: cur_len};
        owed.push_back(beat);
      end
      fill    = 0;
      framing = (body_left != 0);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(frame_beat_t got);
      frame_beat_t want;
      if (owed.size() == 0) begin
        $error("unexpected transfer: out_byte 0x%0h", got.data);
        errors++;
        return;
      end
      want = owed.pop_front();
      compare_field("out_byte", want.data, got.data);
      compare_field("route_group", want.route, got.route);
      compare_field("frame_start", want.start, got.start);
      compare_field("frame_end", want.last, got.last);
      compare_field("frame_length", want.length, got.length);
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx    = RegSyncWord;
  logic [WordW-1:0]   cfg_data   = '0;
  logic               in_valid   = 1'b0;
  logic [7:0]         data_byte  = '0;
  logic               out_ready  = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [7:0]         out_byte_o;
  logic               route_group_o;
  logic               frame_start_o;
  logic               frame_end_o;
  logic [LenW-1:0]    frame_length_o;

  frame_scoreboard sb = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent           = 0;
  int unsigned quiet_cycles   = 0;

  sync_length_deframer_router_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte_o),
    .route_group_o  (route_group_o),
    .frame_start_o  (frame_start_o),
    .frame_end_o    (frame_end_o),
    .frame_length_o (frame_length_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Observe both channels and guard against a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) sb.note_byte(data_byte);
      if (out_valid_o && out_ready) begin
        sb.check_beat('{data: out_byte_o, route: route_group_o, start: frame_start_o,
                        last: frame_end_o, length: frame_length_o});
      end
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) push_byte(w[8*i +: 8]);
  endtask

  // Drop valid, drain every owed beat, then give the pipeline time to settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (HdrBytes + 4) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [WordW-1:0] sync_word, input logic [31:0] min_len,
                               input logic [31:0] max_len, input logic [31:0] spec_len);
    logic [CfgIdxW-1:0] order [4];
    logic [WordW-1:0]   vals [4];
    order = '{RegSyncWord, RegMinLen, RegMaxLen, RegSpecLen};
    vals  = '{sync_word, min_len, max_len, spec_len};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= order[i];
      cfg_data <= vals[i];
      @(posedge clk_i);
      sb.set_reg(order[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] bad_length();
    case ($urandom_range(4))
      0:       return 32'(sb.min_len);
      1:       return 32'(sb.max_len) + 1;
      2:       return HdrBytes;
      3:       return $urandom_range(HdrBytes - 1);
      default: return 32'h8000_0000 | $urandom;
    endcase
  endfunction

  // Mostly well-formed frames; the rest rejected headers, noise and cut-off sync words.
  task automatic send_sequence();
    int unsigned pick;
    logic [31:0] lo, hi, len;
    pick = $urandom_range(99);
    if (pick < 60 && sb.min_len < sb.max_len) begin
      lo = 32'(sb.min_len) + 1;
      hi = (32'(sb.max_len) < lo + 23) ? 32'(sb.max_len) : lo + 23;
      case ($urandom_range(3))
        0: len = lo;
        1: len = hi;
        2: begin
          if (sb.spec_len > sb.min_len && 32'(sb.spec_len) <= hi) len = sb.spec_len;
          else len = $urandom_range(hi, lo);
        end
        default: len = $urandom_range(hi, lo);
      endcase
      push_word(sb.sync_word);
      push_word(len);
      repeat (len - HdrBytes) push_byte($urandom);
    end else if (pick < 78) begin
      push_word(sb.sync_word);
      push_word(bad_length());
    end else if (pick < 90) begin
      repeat ($urandom_range(6, 1)) push_byte($urandom);
    end else begin
      for (int i = 3; i > 3 - int'($urandom_range(3, 1)); i--) push_byte(sb.sync_word[8*i +: 8]);
      push_byte($urandom);
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned n_bytes);
    int unsigned target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = sent + n_bytes;
    while (sent < target) send_sequence();
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: noise, negative length, then a special-length frame left open.
    apply_setting(SyncWordRst, 8, 20, 12);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_word(SyncWordRst);
    push_word(32'h8000_0010);
    push_word(SyncWordRst);
    push_word(32'd12);
    push_byte(8'hA5);
    push_byte(8'h5A);
    drain();

    // The open frame keeps its latched length and route across this change.
    apply_setting(32'h0000_0000, 8, 40, 20);
    run_phase(0, 0, PhaseBytes);
    apply_setting($urandom, 30, 1048576, 0);
    run_phase(87, 0, PhaseBytes);
    apply_setting(32'hFFFF_FFFF, 16, 48, 1048576);
    run_phase(0, 87, PhaseBytes);
    apply_setting($urandom, 10, 36, 25);
    run_phase(23, 23, PhaseBytes);
    // Bounds at their extremes: every header is rejected.
    apply_setting(SyncWordRst, 1048576, 8, SpecLenRst);
    run_phase(23, 23, 16);

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
